// ----- sv/apq_pkg.sv -----
// types, request and status codes shared by the ready queue modules
`timescale 1ns / 1ps

package apq_pkg;

    localparam int ID_W    = 8;
    localparam int SCORE_W = 10;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int ENTRY_W = ID_W + SCORE_W;

    localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_NEW  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REINSERT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FRONT    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_AGE      = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ID_W-1:0]    job_id;
        logic [SCORE_W-1:0] score;
    } t_in_word;

    typedef struct packed {
        logic               popped_valid;
        logic [ID_W-1:0]    popped_id;
        logic [SCORE_W-1:0] popped_score;
        logic [STAT_W-1:0]  status;
        logic               is_empty;
        logic [OCC_W-1:0]   occupancy;
    } t_out_word;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_DATA,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_AGE_RD,
        S_AGE_WR,
        S_DONE
    } t_state;

endpackage

// ----- sv/apq_ram.sv -----
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module apq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/apq_obuf.sv -----
// result word output register with valid and stall
`timescale 1ns / 1ps

module apq_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  apq_pkg::t_out_word i_word,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output apq_pkg::t_out_word o_out_word
);

    import apq_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_word r_word;

    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

// ----- sv/aging_priority_ready_queue.sv -----
// ready queue top level: ring buffer in ram, request sequencer, result register
//
//   channel | direction | handshake                 | word
//   in      | input     | i_in_valid / o_in_stall   | i_in_word  (t_in_word)
//   out     | output    | o_out_valid / i_out_stall | o_out_word (t_out_word)
//
// one request at a time; append, push front, rejected requests and empty pops go straight to the
// result state, and a pop reads the head entry first; sorted insert and age visit or move entries
// one at a time, each with a ram read, then a compare or a write
// reset empties the queue at once; the ram contents are not cleared
// a new word is taken while an earlier result waits on a stalled output

`timescale 1ns / 1ps

module aging_priority_ready_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  apq_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output apq_pkg::t_out_word o_out_word
);

    import apq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(i);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_pos, n_pos;
    logic [REQ_W-1:0]    r_req, n_req;
    logic [ID_W-1:0]     r_id, n_id;
    logic [SCORE_W-1:0]  r_score, n_score;
    logic [STAT_W-1:0]   r_status, n_status;
    logic                r_pv, n_pv;
    logic [ID_W-1:0]     r_pid, n_pid;
    logic [SCORE_W-1:0]  r_psc, n_psc;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_rdata;

    logic          full;
    logic          hit;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic          obuf_load;
    logic          obuf_free;
    t_out_word     res_word;
    logic [CW+OCC_W-1:0] occ_ext;

    assign full     = (r_count == CW'(QUEUE_DEPTH));
    assign head_dec = (r_head == '0) ? AW'(QUEUE_DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign hit      = (r_req == REQ_REINSERT) ? (ram_rdata.score >= r_score)
                                              : (ram_rdata.score > r_score);
    assign o_in_stall = (r_state != S_IDLE);

    assign occ_ext = (CW+OCC_W)'(r_count);
    always_comb begin
        res_word.popped_valid = r_pv;
        res_word.popped_id    = r_pid;
        res_word.popped_score = r_psc;
        res_word.status       = r_status;
        res_word.is_empty     = (r_count == '0);
        res_word.occupancy    = occ_ext[OCC_W-1:0];
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_req     = r_req;
        n_id      = r_id;
        n_score   = r_score;
        n_status  = r_status;
        n_pv      = r_pv;
        n_pid     = r_pid;
        n_psc     = r_psc;
        ram_we    = 1'b0;
        ram_waddr = f_phys(r_head, r_idx);
        ram_wdata = '{id: r_id, score: r_score};
        ram_raddr = r_head;
        obuf_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_in_word.req_type;
                    n_id     = i_in_word.job_id;
                    n_score  = i_in_word.score;
                    n_status = STAT_OK;
                    n_pv     = 1'b0;
                    n_pid    = '0;
                    n_psc    = '0;
                    n_idx    = '0;
                    n_state  = S_DONE;
                    case (i_in_word.req_type)
                        REQ_POP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_state = S_POP_DATA;
                            end
                        end
                        REQ_AGE: begin
                            n_state = S_AGE_RD;
                        end
                        REQ_APPEND, REQ_INS_NEW, REQ_REINSERT, REQ_FRONT: begin
                            if (full) begin
                                n_status = STAT_FULL;
                            end else if (i_in_word.req_type == REQ_APPEND) begin
                                ram_we    = 1'b1;
                                ram_waddr = f_phys(r_head, r_count);
                                ram_wdata = '{id: i_in_word.job_id, score: i_in_word.score};
                                n_count   = r_count + 1'b1;
                            end else if (i_in_word.req_type == REQ_FRONT) begin
                                ram_we    = 1'b1;
                                ram_waddr = head_dec;
                                ram_wdata = '{id: i_in_word.job_id, score: i_in_word.score};
                                n_head    = head_dec;
                                n_count   = r_count + 1'b1;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            n_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_POP_DATA: begin
                n_pv    = 1'b1;
                n_pid   = ram_rdata.id;
                n_psc   = ram_rdata.score;
                n_head  = head_inc;
                n_count = r_count - 1'b1;
                n_state = S_DONE;
            end
            S_SCAN_RD: begin
                if (r_idx == r_count) begin
                    n_pos   = r_idx;
                    n_state = S_SHIFT_RD;
                end else begin
                    ram_raddr = f_phys(r_head, r_idx);
                    n_state   = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    n_pos   = r_idx;
                    n_idx   = r_count;
                    n_state = S_SHIFT_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_idx == r_pos) begin
                    ram_we    = 1'b1;
                    ram_waddr = f_phys(r_head, r_pos);
                    n_count   = r_count + 1'b1;
                    n_state   = S_DONE;
                end else begin
                    ram_raddr = f_phys(r_head, r_idx - 1'b1);
                    n_state   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = f_phys(r_head, r_idx);
                ram_wdata = ram_rdata;
                n_idx     = r_idx - 1'b1;
                n_state   = S_SHIFT_RD;
            end
            S_AGE_RD: begin
                if (r_idx == r_count) begin
                    n_state = S_DONE;
                end else begin
                    ram_raddr = f_phys(r_head, r_idx);
                    n_state   = S_AGE_WR;
                end
            end
            S_AGE_WR: begin
                ram_we          = 1'b1;
                ram_waddr       = f_phys(r_head, r_idx);
                ram_wdata.id    = ram_rdata.id;
                ram_wdata.score = (ram_rdata.score == '0) ? '0 : ram_rdata.score - 1'b1;
                n_idx           = r_idx + 1'b1;
                n_state         = S_AGE_RD;
            end
            S_DONE: begin
                if (obuf_free) begin
                    obuf_load = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_req    <= n_req;
        r_id     <= n_id;
        r_score  <= n_score;
        r_status <= n_status;
        r_pv     <= n_pv;
        r_pid    <= n_pid;
        r_psc    <= n_psc;
    end

    apq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    apq_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (obuf_load),
        .i_word      (res_word),
        .o_free      (obuf_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- tb/ready_queue_checker.sv -----
// predictor and result comparison for the aging priority ready queue
`timescale 1ns / 1ps

module ready_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  apq_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  apq_pkg::t_out_word i_out_word,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_empty_pops,
    output int                 o_full_drops
);

    import apq_pkg::*;

    t_entry    held [QUEUE_DEPTH];
    int        held_count;
    t_out_word expected_words [$];

    function automatic t_out_word serve_request(input t_in_word w);
        t_out_word r;
        int        pos;
        r = '0;
        r.status = STAT_OK;
        case (w.req_type)
            REQ_POP: begin
                if (held_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.popped_valid = 1'b1;
                    r.popped_id    = held[0].id;
                    r.popped_score = held[0].score;
                    for (int i = 1; i < held_count; i++) held[i-1] = held[i];
                    held_count--;
                end
            end
            REQ_AGE: begin
                for (int i = 0; i < held_count; i++) begin
                    if (held[i].score != '0) held[i].score = held[i].score - 1'b1;
                end
            end
            REQ_APPEND, REQ_INS_NEW, REQ_REINSERT, REQ_FRONT: begin
                if (held_count >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (w.req_type == REQ_APPEND) begin
                        pos = held_count;
                    end else if (w.req_type == REQ_FRONT) begin
                        pos = 0;
                    end else begin
                        // reinsert goes ahead of equal scores, a new job behind them
                        pos = 0;
                        while (pos < held_count) begin
                            if (w.req_type == REQ_REINSERT ? held[pos].score >= w.score
                                                           : held[pos].score > w.score) break;
                            pos++;
                        end
                    end
                    for (int i = held_count; i > pos; i--) held[i] = held[i-1];
                    held[pos].id    = w.job_id;
                    held[pos].score = w.score;
                    held_count++;
                end
            end
            default: begin
            end
        endcase
        r.is_empty  = (held_count == 0);
        r.occupancy = held_count[OCC_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            held_count = 0;
            expected_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                want = serve_request(i_in_word);
                expected_words.push_back(want);
                if (want.status == STAT_EMPTY) o_empty_pops++;
                if (want.status == STAT_FULL) o_full_drops++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: result word with nothing expected: %h", $time, i_out_word);
                end else begin
                    want = expected_words.pop_front();
                    o_checked++;
                    if (i_out_word.popped_valid !== want.popped_valid ||
                        i_out_word.popped_id    !== want.popped_id    ||
                        i_out_word.popped_score !== want.popped_score ||
                        i_out_word.status       !== want.status       ||
                        i_out_word.is_empty     !== want.is_empty     ||
                        i_out_word.occupancy    !== want.occupancy) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("%0t: result %0d expected pv %0d id %0d sc %0d st %0d e %0d occ %0d",
                                     $time, o_checked, want.popped_valid, want.popped_id,
                                     want.popped_score, want.status, want.is_empty,
                                     want.occupancy);
                            $display("%0t: result %0d got      pv %0d id %0d sc %0d st %0d e %0d occ %0d",
                                     $time, o_checked, i_out_word.popped_valid,
                                     i_out_word.popped_id, i_out_word.popped_score,
                                     i_out_word.status, i_out_word.is_empty,
                                     i_out_word.occupancy);
                        end
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ----- tb/tb.sv -----
// testbench top: clock, reset, request stimulus, output stalls and verdict
`timescale 1ns / 1ps

module tb;

    import apq_pkg::*;

    localparam int QUEUE_DEPTH      = 16;
    localparam int RANDOM_WORDS     = 1875;
    localparam int HOLD_AT_WORD     = 500;
    localparam int DRAIN_AT_WORD    = 1200;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 80;

    // request codes the block treats as no operation
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int mismatches;
    int pending;
    int checked;
    int empty_pops;
    int full_drops;

    int words_sent   = 0;
    int burst_left   = 0;
    int holds_asked  = 0;
    int holds_served = 0;

    aging_priority_ready_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    ready_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_empty_pops (empty_pops),
        .o_full_drops (full_drops)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin : watchdog
        #1_000_000;
        $display("aging_priority_ready_queue test failed");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic offer_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                                 input logic [SCORE_W-1:0] sc);
        t_in_word w;
        w.req_type = req;
        w.job_id   = id;
        w.score    = sc;
        in_word  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        words_sent++;
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    function automatic logic [REQ_W-1:0] pick_request(input t_mix mix);
        int               roll;
        int               edges [7];
        logic [REQ_W-1:0] codes [8];
        roll  = $urandom_range(0, 99);
        codes = '{REQ_POP, REQ_APPEND, REQ_INS_NEW, REQ_REINSERT, REQ_FRONT, REQ_AGE,
                  REQ_SPARE_6, REQ_SPARE_7};
        case (mix)
            MIX_FILL:  edges = '{10, 25, 45, 65, 78, 94, 97};
            MIX_DRAIN: edges = '{50, 58, 66, 74, 80, 94, 97};
            default:   edges = '{30, 40, 52, 64, 74, 92, 96};
        endcase
        for (int k = 0; k < 7; k++) begin
            if (roll < edges[k]) return codes[k];
        end
        return codes[7];
    endfunction

    // small scores give ties and let aging reach zero
    function automatic logic [SCORE_W-1:0] pick_score();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return SCORE_W'($urandom_range(0, 7));
        if (roll == 4) return $urandom_range(0, 1) ? {SCORE_W{1'b1}} : '0;
        return SCORE_W'($urandom_range(0, 1023));
    endfunction

    initial begin : receiver
        int pattern;
        int stretch_left;
        pattern      = 0;
        stretch_left = 0;
        forever begin
            @(negedge clk);
            if (holds_asked != holds_served) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                holds_served++;
            end
            if (stretch_left == 0) begin
                pattern      = $urandom_range(0, 2);
                stretch_left = $urandom_range(20, 60);
            end
            stretch_left--;
            case (pattern)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= ((stretch_left % 7) < 4);
            endcase
        end
    end

    initial begin : stimulus
        t_mix             mix;
        int               mix_left;
        logic [REQ_W-1:0] insert_codes [4];
        insert_codes = '{REQ_APPEND, REQ_INS_NEW, REQ_REINSERT, REQ_FRONT};
        mix      = MIX_EVEN;
        mix_left = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue cases
        offer_request(REQ_POP, 8'd0, 10'd0);
        offer_request(REQ_AGE, 8'd255, 10'd1023);
        offer_request(REQ_SPARE_6, 8'd255, 10'd1023);
        offer_request(REQ_SPARE_7, 8'd0, 10'd0);
        // extremes, ties for both sorted inserts, aging at zero
        offer_request(REQ_APPEND, 8'd0, 10'd0);
        offer_request(REQ_APPEND, 8'd255, 10'd1023);
        offer_request(REQ_INS_NEW, 8'd1, 10'd0);
        offer_request(REQ_REINSERT, 8'd2, 10'd0);
        offer_request(REQ_FRONT, 8'haa, 10'd512);
        offer_request(REQ_INS_NEW, 8'd3, 10'd512);
        offer_request(REQ_REINSERT, 8'd4, 10'd512);
        offer_request(REQ_AGE, 8'd0, 10'd0);
        // fill up, then every insert kind against a full queue
        for (int k = 0; k < 9; k++)
            offer_request(insert_codes[k % 4], ID_W'(16 + k), SCORE_W'(k * 113));
        for (int k = 0; k < 4; k++)
            offer_request(insert_codes[k], 8'h55, 10'h2aa);
        offer_request(REQ_AGE, 8'd0, 10'd0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (mix_left == 0) begin
                mix      = t_mix'($urandom_range(0, 2));
                mix_left = $urandom_range(10, 50);
            end
            mix_left--;
            if (n == HOLD_AT_WORD) holds_asked++;
            if (n == DRAIN_AT_WORD) begin
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
                @(negedge clk);
            end
            offer_request(pick_request(mix), ID_W'($urandom_range(0, 255)), pick_score());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("requests sent %0d, results checked %0d", words_sent, checked);
        $display("pops on an empty queue %0d, inserts dropped on a full queue %0d",
                 empty_pops, full_drops);
        if (mismatches == 0 && pending == 0) begin
            $display("aging_priority_ready_queue test passed");
        end else begin
            $display("aging_priority_ready_queue test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/apq_pkg.sv
sv/apq_ram.sv
sv/apq_obuf.sv
sv/aging_priority_ready_queue.sv
tb/ready_queue_checker.sv
tb/tb.sv
